### rtl/core/itps_pkg.sv
// types, constants and helper functions of the integer text parser
package itps_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OddW    = 28;
  localparam int unsigned ShiftW  = 6;

  localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;

  // character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpK   = 8'h4b;
  localparam logic [7:0] ChLowK  = 8'h6b;
  localparam logic [7:0] ChUpM   = 8'h4d;
  localparam logic [7:0] ChLowM  = 8'h6d;
  localparam logic [7:0] ChUpG   = 8'h47;
  localparam logic [7:0] ChLowG  = 8'h67;
  localparam logic [7:0] ChUpT   = 8'h54;
  localparam logic [7:0] ChLowT  = 8'h74;

  typedef enum logic [2:0] {
    PH_LEAD, PH_SIGN, PH_ZERO, PH_HEXP, PH_DIG, PH_TAIL, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NO_DIGITS  = 3'd2,
    ST_BAD_SUFFIX = 3'd3,
    ST_RANGE      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SFX_NONE, SFX_KIB, SFX_KILO, SFX_MIB, SFX_MEGA,
    SFX_GIB, SFX_GIGA, SFX_TIB, SFX_TERA
  } suffix_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_VALUE = 2'd0,
    REG_MAX_VALUE = 2'd1
  } cfg_reg_e;

  // multiplier split as odd factor times a power of two
  typedef struct packed {
    logic [ShiftW-1:0] shift;
    logic [OddW-1:0]   odd;
  } scale_t;

  // control carried along the result pipeline
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    negative;
  } ctl_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // {valid, value} of a digit in the current base
  function automatic logic [4:0] digit_of(logic [7:0] c, logic hex);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= ChZero) && (c <= ChNine)) begin
      d = c - ChZero;
      return {1'b1, d[3:0]};
    end
    if (hex && (c >= ChLowA) && (c <= ChLowF)) begin
      d = c - ChLowA + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (hex && (c >= ChUpA) && (c <= ChUpF)) begin
      d = c - ChUpA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0;
  endfunction

  function automatic suffix_e suffix_of(logic [7:0] c);
    suffix_e s;
    s = SFX_NONE;
    if (c == ChUpK)  s = SFX_KIB;
    if (c == ChLowK) s = SFX_KILO;
    if (c == ChUpM)  s = SFX_MIB;
    if (c == ChLowM) s = SFX_MEGA;
    if (c == ChUpG)  s = SFX_GIB;
    if (c == ChLowG) s = SFX_GIGA;
    if (c == ChUpT)  s = SFX_TIB;
    if (c == ChLowT) s = SFX_TERA;
    return s;
  endfunction

  // 10^n = 2^n * 5^n
  function automatic scale_t scale_of(suffix_e s);
    scale_t r;
    unique case (s)
      SFX_KIB:  r = '{shift: 6'd10, odd: 28'd1};
      SFX_KILO: r = '{shift: 6'd3,  odd: 28'd125};
      SFX_MIB:  r = '{shift: 6'd20, odd: 28'd1};
      SFX_MEGA: r = '{shift: 6'd6,  odd: 28'd15625};
      SFX_GIB:  r = '{shift: 6'd30, odd: 28'd1};
      SFX_GIGA: r = '{shift: 6'd9,  odd: 28'd1953125};
      SFX_TIB:  r = '{shift: 6'd40, odd: 28'd1};
      SFX_TERA: r = '{shift: 6'd12, odd: 28'd244140625};
      default:  r = '{shift: 6'd0,  odd: 28'd1};
    endcase
    return r;
  endfunction

endpackage

### rtl/core/integer_text_parser_with_suffix_core.sv
// integer text parser with size suffix, byte stream in, one result per string out
//
// input channel: one text byte per transfer on char_code_i with last_i marking
// the final byte; a transfer happens when in_valid_i is high and in_stall_o low.
// a byte is taken in every cycle unless in_stall_o is high; only the byte flagged last produces a result.
// output channel: status_o and value_o, a transfer when out_valid_o is high and
// out_stall_i low. value_o is zero unless status_o reports ok.
// config channel: cfg_index_i selects min_value (0) or max_value (1), written
// when cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always high.
// the result of a string passes through the scaling pipeline (split multiply,
// sum, shift and clip, negate, range check); throughput is one byte per cycle
// at every point while the pipeline is not held.
// reset clears the parse state and the pipeline and loads min_value = -2^63,
// max_value = 2^63-1. when the receiver stalls a waiting result, the whole
// pipeline holds and in_stall_o is raised in the same cycle.
module integer_text_parser_with_suffix_core
  import itps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [63:0] value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic signed [63:0] cfg_data_i
);

  // pipeline moves unless a finished result is held back
  logic adv;
  logic in_acc;

  // configuration registers
  logic signed [63:0] min_q;
  logic signed [63:0] max_q;

  // parse state
  phase_e      phase_q, phase_d, fed_phase;
  logic [63:0] mag_q, mag_d, fed_mag;
  logic        neg_q, neg_d, fed_neg;
  logic        hex_q, hex_d, fed_hex;
  suffix_e     sfx_q, sfx_d, fed_sfx;
  status_e     err_q, err_d, fed_err;
  status_e     snap_err;

  // digit arithmetic
  logic [4:0]  dig;
  logic        dig_ok;
  logic [67:0] acc_sum;
  logic [63:0] added_mag;
  suffix_e     sfx_in;

  // pipeline stages
  ctl_t        s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q, s5_ctl_q;
  logic [63:0] s1_mag_q;
  suffix_e     s1_sfx_q;

  logic [63:0] s2_u;
  scale_t      s2_scale;
  logic [59:0] s2_lo_d, s2_hi_d, s2_lo_q, s2_hi_q;
  logic [ShiftW-1:0] s2_shift_q, s3_shift_q;

  logic [91:0]  s3_prod_d, s3_prod_q;

  logic [131:0] s4_sh;
  logic [63:0]  s4_limit;
  logic         s4_ovf;
  logic [63:0]  s4_u_d, s4_u_q;

  logic [63:0]  s5_v_q;

  logic         out_in_range;
  status_e      out_status_d;
  logic         out_valid_q;
  status_e      out_status_q;
  logic [63:0]  out_value_q;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign in_acc      = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= $signed(TopBit);
      max_q <= $signed(TopBit - 64'd1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_MIN_VALUE) min_q <= cfg_data_i;
      if (cfg_index_i == REG_MAX_VALUE) max_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // digit accumulate: mag * base + d, saturating at 2^63
  assign dig     = digit_of(char_code_i, hex_q);
  assign dig_ok  = dig[4];
  assign sfx_in  = suffix_of(char_code_i);
  assign acc_sum = (hex_q ? {mag_q, 4'b0}
                          : ({1'b0, mag_q, 3'b0} + {3'b0, mag_q, 1'b0}))
                 + {64'b0, dig[3:0]};
  assign added_mag = (acc_sum > {4'b0, TopBit}) ? TopBit : acc_sum[63:0];

  // next parse state for one byte
  always_comb begin
    fed_phase = phase_q;
    fed_mag   = mag_q;
    fed_neg   = neg_q;
    fed_hex   = hex_q;
    fed_sfx   = sfx_q;
    fed_err   = err_q;
    if (phase_q != PH_DONE) begin
      if (char_code_i == ChNul) begin
        // string ends early
        fed_phase = PH_DONE;
        if (phase_q == PH_LEAD) fed_err = ST_EMPTY;
        if (phase_q == PH_SIGN) fed_err = ST_NO_DIGITS;
        if (phase_q == PH_HEXP) fed_err = ST_BAD_SUFFIX;
      end else begin
        unique case (phase_q)
          PH_LEAD: begin
            if (is_space(char_code_i)) begin
              fed_phase = PH_LEAD;
            end else if (char_code_i == ChPlus || char_code_i == ChMinus) begin
              fed_neg   = (char_code_i == ChMinus);
              fed_phase = PH_SIGN;
            end else if (dig_ok) begin
              fed_mag   = added_mag;
              fed_phase = (char_code_i == ChZero) ? PH_ZERO : PH_DIG;
            end else begin
              fed_err   = ST_NO_DIGITS;
              fed_phase = PH_DONE;
            end
          end
          PH_SIGN: begin
            if (dig_ok) begin
              fed_mag   = added_mag;
              fed_phase = PH_DIG;
            end else begin
              fed_err   = ST_NO_DIGITS;
              fed_phase = PH_DONE;
            end
          end
          PH_HEXP: begin
            if (dig_ok) begin
              fed_mag   = added_mag;
              fed_phase = PH_DIG;
            end else begin
              fed_err   = ST_BAD_SUFFIX;
              fed_phase = PH_DONE;
            end
          end
          PH_ZERO, PH_DIG, PH_TAIL: begin
            if (phase_q == PH_ZERO && (char_code_i == ChLowX || char_code_i == ChUpX)) begin
              fed_hex   = 1'b1;
              fed_phase = PH_HEXP;
            end else if (phase_q != PH_TAIL && dig_ok) begin
              fed_mag   = added_mag;
              fed_phase = PH_DIG;
            end else if (is_space(char_code_i)) begin
              fed_phase = PH_TAIL;
            end else if (sfx_in != SFX_NONE) begin
              fed_sfx   = sfx_in;
              fed_phase = PH_DONE;
            end else begin
              fed_err   = ST_BAD_SUFFIX;
              fed_phase = PH_DONE;
            end
          end
          default: begin
            fed_phase = phase_q;
          end
        endcase
      end
    end
  end

  // end of string on the last byte, and the register update
  always_comb begin
    snap_err = fed_err;
    if (fed_phase == PH_LEAD) snap_err = ST_EMPTY;
    if (fed_phase == PH_SIGN) snap_err = ST_NO_DIGITS;
    if (fed_phase == PH_HEXP) snap_err = ST_BAD_SUFFIX;

    phase_d = phase_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    hex_d   = hex_q;
    sfx_d   = sfx_q;
    err_d   = err_q;
    if (in_acc) begin
      if (last_i) begin
        // parse state starts over for the next string
        phase_d = PH_LEAD;
        mag_d   = 64'd0;
        neg_d   = 1'b0;
        hex_d   = 1'b0;
        sfx_d   = SFX_NONE;
        err_d   = ST_OK;
      end else begin
        phase_d = fed_phase;
        mag_d   = fed_mag;
        neg_d   = fed_neg;
        hex_d   = fed_hex;
        sfx_d   = fed_sfx;
        err_d   = fed_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      mag_q   <= 64'd0;
      neg_q   <= 1'b0;
      hex_q   <= 1'b0;
      sfx_q   <= SFX_NONE;
      err_q   <= ST_OK;
    end else begin
      phase_q <= phase_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      hex_q   <= hex_d;
      sfx_q   <= sfx_d;
      err_q   <= err_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: clip to the signed limit, split multiply by the odd factor
  assign s2_u     = (!s1_ctl_q.negative && s1_mag_q == TopBit) ? (TopBit - 64'd1)
                                                              : s1_mag_q;
  assign s2_scale = scale_of(s1_sfx_q);
  assign s2_lo_d  = 60'(s2_u[31:0]) * 60'(s2_scale.odd);
  assign s2_hi_d  = 60'(s2_u[63:32]) * 60'(s2_scale.odd);

  // stage 3: combine the partial products
  assign s3_prod_d = {s2_hi_q, 32'b0} + {32'b0, s2_lo_q};

  // stage 4: power-of-two shift and saturation
  assign s4_sh    = {40'b0, s3_prod_q} << s3_shift_q;
  assign s4_limit = s3_ctl_q.negative ? TopBit : (TopBit - 64'd1);
  assign s4_ovf   = (|s4_sh[131:64])
                 || (s4_sh[63] && (s3_ctl_q.negative ? (|s4_sh[62:0]) : 1'b1));
  assign s4_u_d   = s4_ovf ? s4_limit : s4_sh[63:0];

  // output stage: range check against the registers
  assign out_in_range = !($signed(s5_v_q) < min_q) && !($signed(s5_v_q) > max_q);
  assign out_status_d = (s5_ctl_q.status == ST_OK && !out_in_range) ? ST_RANGE
                                                                   : s5_ctl_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q    <= '{valid: 1'b0, status: ST_OK, negative: 1'b0};
      s2_ctl_q    <= '{valid: 1'b0, status: ST_OK, negative: 1'b0};
      s3_ctl_q    <= '{valid: 1'b0, status: ST_OK, negative: 1'b0};
      s4_ctl_q    <= '{valid: 1'b0, status: ST_OK, negative: 1'b0};
      s5_ctl_q    <= '{valid: 1'b0, status: ST_OK, negative: 1'b0};
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_ctl_q    <= '{valid: in_acc && last_i, status: snap_err, negative: fed_neg};
      s2_ctl_q    <= s1_ctl_q;
      s3_ctl_q    <= s2_ctl_q;
      s4_ctl_q    <= s3_ctl_q;
      s5_ctl_q    <= s4_ctl_q;
      out_valid_q <= s5_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mag_q     <= fed_mag;
      s1_sfx_q     <= fed_sfx;
      s2_lo_q      <= s2_lo_d;
      s2_hi_q      <= s2_hi_d;
      s2_shift_q   <= s2_scale.shift;
      s3_prod_q    <= s3_prod_d;
      s3_shift_q   <= s2_shift_q;
      s4_u_q       <= s4_u_d;
      s5_v_q       <= s4_ctl_q.negative ? (64'd0 - s4_u_q) : s4_u_q;
      out_status_q <= out_status_d;
      out_value_q  <= (out_status_d == ST_OK) ? s5_v_q : 64'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_o     = $signed(out_value_q);

  // ---------------------------------------------------------------------------
  // assertions

  a_mag_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= TopBit)
    else $error("magnitude above 2^63");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> (phase_q == PH_LEAD) && (mag_q == 64'd0))
    else $error("parse state not cleared after last byte");

  a_last_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> s1_ctl_q.valid)
    else $error("last byte produced no pipeline entry");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (value_o == 64'sd0))
    else $error("nonzero value with error status");

  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |-> (value_o >= min_q) && (value_o <= max_q))
    else $error("ok result outside the configured range");

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the integer text parser with size suffix
module testbench
  import itps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] S64Min = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int RandomBytes = 700;
  localparam int DrainCycles = 12;   // drain margin after the last owed result

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value;
  } result_t;

  // one line of the directed plan: either a limit update or a string
  typedef struct {
    bit                 is_cfg;
    string              text;
    int                 nul_at;
    bit                 typed;
    status_e            st;
    logic [63:0]        val;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
  } row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         char_code;
  logic               last;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic signed [63:0] value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic signed [63:0] cfg_data;

  integer_text_parser_with_suffix_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .char_code_i (char_code),
    .last_i      (last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .value_o     (value),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // parser shadow: parse state of the string in flight plus the two limits
  // ---------------------------------------------------------------------------
  phase_e             txt_phase;
  logic [63:0]        txt_mag;
  logic               txt_neg;
  logic               txt_hex;
  suffix_e            txt_sfx;
  status_e            txt_err;
  logic signed [63:0] lim_lo = S64Min;
  logic signed [63:0] lim_hi = S64Max;

  result_t     pending_results[$];   // results owed by the parser, oldest first
  logic [7:0]  text_buf[$];          // bytes of the string about to be sent
  row_t        plan[$];
  int          fail_count = 0;
  int          burst_left = 0;

  logic [7:0] sfx_letters[8] = '{ChUpK, ChLowK, ChUpM, ChLowM, ChUpG, ChLowG, ChUpT, ChLowT};

  function automatic logic blank(logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  // {found, value} of c as a digit of the current base
  function automatic logic [4:0] digit_in_base(logic [7:0] c, logic hex);
    logic [7:0] d;
    d = 8'h00;
    if (c >= ChZero && c <= ChNine) d = c - ChZero + 8'h10;
    else if (hex && c >= ChLowA && c <= ChLowF) d = c - ChLowA + 8'h1a;
    else if (hex && c >= ChUpA && c <= ChUpF) d = c - ChUpA + 8'h1a;
    return d[4:0];
  endfunction

  function automatic suffix_e suffix_letter(logic [7:0] c);
    case (c)
      ChUpK:   return SFX_KIB;
      ChLowK:  return SFX_KILO;
      ChUpM:   return SFX_MIB;
      ChLowM:  return SFX_MEGA;
      ChUpG:   return SFX_GIB;
      ChLowG:  return SFX_GIGA;
      ChUpT:   return SFX_TIB;
      ChLowT:  return SFX_TERA;
      default: return SFX_NONE;
    endcase
  endfunction

  function automatic logic [63:0] scale_factor(suffix_e s);
    case (s)
      SFX_KIB:  return 64'd1024;
      SFX_KILO: return 64'd1000;
      SFX_MIB:  return 64'd1048576;
      SFX_MEGA: return 64'd1000000;
      SFX_GIB:  return 64'd1073741824;
      SFX_GIGA: return 64'd1000000000;
      SFX_TIB:  return 64'd1099511627776;
      SFX_TERA: return 64'd1000000000000;
      default:  return 64'd1;
    endcase
  endfunction

  function automatic void clear_text();
    txt_phase = PH_LEAD;
    txt_mag   = '0;
    txt_neg   = 1'b0;
    txt_hex   = 1'b0;
    txt_sfx   = SFX_NONE;
    txt_err   = ST_OK;
  endfunction

  // magnitude sticks at 2^63 once it would pass it
  function automatic void take_digit(logic [3:0] d);
    logic [63:0] base;
    base = txt_hex ? 64'd16 : 64'd10;
    if (txt_mag > (TopBit - {60'd0, d}) / base) txt_mag = TopBit;
    else txt_mag = txt_mag * base + {60'd0, d};
  endfunction

  // end of string, either by NUL or by the last flag
  function automatic void end_text();
    if (txt_phase == PH_LEAD) txt_err = ST_EMPTY;
    else if (txt_phase == PH_SIGN) txt_err = ST_NO_DIGITS;
    else if (txt_phase == PH_HEXP) txt_err = ST_BAD_SUFFIX;
    txt_phase = PH_DONE;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    logic [4:0] dg;
    if (txt_phase == PH_DONE) return;
    if (c == ChNul) begin
      end_text();
      return;
    end
    if (txt_phase == PH_LEAD) begin
      if (blank(c)) return;
      if (c == ChPlus || c == ChMinus) begin
        txt_neg   = (c == ChMinus);
        txt_phase = PH_SIGN;
        return;
      end
      dg = digit_in_base(c, 1'b0);
      if (dg[4]) begin
        take_digit(dg[3:0]);
        // only an unsigned leading zero opens the door to hex
        txt_phase = (c == ChZero) ? PH_ZERO : PH_DIG;
      end else begin
        txt_err   = ST_NO_DIGITS;
        txt_phase = PH_DONE;
      end
      return;
    end
    if (txt_phase == PH_SIGN || txt_phase == PH_HEXP) begin
      dg = digit_in_base(c, txt_hex);
      if (dg[4]) begin
        take_digit(dg[3:0]);
        txt_phase = PH_DIG;
      end else begin
        txt_err   = (txt_phase == PH_SIGN) ? ST_NO_DIGITS : ST_BAD_SUFFIX;
        txt_phase = PH_DONE;
      end
      return;
    end
    if (txt_phase == PH_ZERO && (c == ChLowX || c == ChUpX)) begin
      txt_hex   = 1'b1;
      txt_phase = PH_HEXP;
      return;
    end
    if (txt_phase != PH_TAIL) begin
      dg = digit_in_base(c, txt_hex);
      if (dg[4]) begin
        take_digit(dg[3:0]);
        txt_phase = PH_DIG;
        return;
      end
    end
    if (blank(c)) begin
      txt_phase = PH_TAIL;
      return;
    end
    // one suffix byte closes the number, anything else there is an error
    txt_sfx = suffix_letter(c);
    if (txt_sfx == SFX_NONE) txt_err = ST_BAD_SUFFIX;
    txt_phase = PH_DONE;
  endfunction

  // clip, scale, clip again, sign and range check, then back to a fresh parse
  function automatic result_t finish_result();
    logic [63:0] cap;
    logic [63:0] u;
    logic [63:0] m;
    logic [63:0] v;
    status_e     st;
    end_text();
    st = txt_err;
    v  = '0;
    if (st == ST_OK) begin
      cap = txt_neg ? TopBit : TopBit - 64'd1;
      u   = (txt_mag > cap) ? cap : txt_mag;
      m   = scale_factor(txt_sfx);
      u   = (u > cap / m) ? cap : u * m;
      v   = txt_neg ? 64'd0 - u : u;
      if ($signed(v) < lim_lo || $signed(v) > lim_hi) begin
        st = ST_RANGE;
        v  = '0;
      end
    end
    clear_text();
    return {st, v};
  endfunction

  // ---------------------------------------------------------------------------
  // clock, mismatch reporting, result monitor, receiver stall pattern
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: %s mismatch, got 0x%h expected 0x%h", $realtime, what, got, want);
    fail_count++;
  endtask

  // every transfer on the result side is compared with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", {61'd0, status}, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) note_mismatch("status", {61'd0, status}, {61'd0, want.status});
        if (value !== want.value) note_mismatch("value", value, want.value);
      end
    end
  end

  // receiver back-pressure: modes last a random while, including no stall at all
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // one byte transfer; the sender runs in bursts separated by idle gaps
  task automatic push_byte(input logic [7:0] c, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    char_code <= c;
    last      <= lst;
    do @(posedge clk); while (in_stall);
    parse_byte(c);
  endtask

  // send text_buf as one string; typed rows carry their own expectation
  task automatic send_text(input bit typed, input status_e st, input logic [63:0] val);
    result_t guess;
    for (int i = 0; i < text_buf.size(); i++) push_byte(text_buf[i], i == text_buf.size() - 1);
    guess = finish_result();
    if (typed) guess = {st, val};
    pending_results.push_back(guess);
  endtask

  // stop sending and let every owed result come out of the pipeline
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic signed [63:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MIN_VALUE) lim_lo = d;
    else lim_hi = d;
  endtask

  task automatic set_limits(input logic signed [63:0] lo, input logic signed [63:0] hi);
    write_reg(REG_MIN_VALUE, lo);
    write_reg(REG_MAX_VALUE, hi);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void plan_text(input string s, input int nul_at, input bit typed,
                                    input status_e st, input logic [63:0] val);
    row_t r;
    r.is_cfg = 1'b0;
    r.text   = s;
    r.nul_at = nul_at;
    r.typed  = typed;
    r.st     = st;
    r.val    = val;
    r.lo     = '0;
    r.hi     = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_limits(input logic signed [63:0] lo, input logic signed [63:0] hi);
    row_t r;
    r.is_cfg = 1'b1;
    r.text   = "";
    r.nul_at = -1;
    r.typed  = 1'b0;
    r.st     = ST_OK;
    r.val    = '0;
    r.lo     = lo;
    r.hi     = hi;
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // random string generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_blank();
    if ($urandom_range(0, 2) == 0) return ChSpace;
    return 8'(ChTab + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] rand_digit(input logic hex);
    int v;
    v = $urandom_range(0, hex ? 15 : 9);
    if (v < 10) return 8'(ChZero + v);
    return 8'(($urandom_range(0, 1) ? ChLowA : ChUpA) + v - 10);
  endfunction

  function automatic logic signed [63:0] pick_limit();
    logic signed [63:0] x;
    case ($urandom_range(0, 4))
      0: x = S64Min;
      1: x = S64Max;
      2, 3: begin
        x = $urandom_range(0, 2000000);
        x = x - 64'sd1000000;
      end
      default: x = {$urandom, $urandom};
    endcase
    return x;
  endfunction

  // mostly well-formed numbers with random content, some noise and broken strings
  function automatic void make_random_text();
    int   kind;
    int   n;
    logic signed_txt;
    logic hex;
    text_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) text_buf.push_back(rand_blank());
    signed_txt = 1'b1;
    case ($urandom_range(0, 3))
      0:       text_buf.push_back(ChPlus);
      1:       text_buf.push_back(ChMinus);
      default: signed_txt = 1'b0;
    endcase
    hex = !signed_txt && ($urandom_range(0, 3) == 0);
    if (hex) begin
      text_buf.push_back(ChZero);
      text_buf.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
    end
    // long digit runs can drive the magnitude into saturation
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 6);
    repeat (n) text_buf.push_back(rand_digit(hex));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(rand_blank());
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: text_buf.push_back(sfx_letters[$urandom_range(0, 7)]);
      5:             text_buf.push_back(8'($urandom_range(33, 126)));
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
    if (kind == 1) begin
      // broken string: cut short or one byte replaced, NUL included
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(1, text_buf.size());
        while (text_buf.size() > n) void'(text_buf.pop_back());
      end else begin
        text_buf[$urandom_range(0, text_buf.size() - 1)] =
          ($urandom_range(0, 2) == 0) ? ChNul : 8'($urandom_range(0, 255));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                 sent;
    int                 strings;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] tmp;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    char_code = '0;
    last      = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_VALUE;
    cfg_data  = '0;
    clear_text();

    // directed plan, reset limits first
    plan_text("0", -1, 1, ST_OK, 64'd0);
    plan_text(" \t\n\v\f\r-42", -1, 1, ST_OK, -64'sd42);
    plan_text("+7k", -1, 1, ST_OK, 64'd7000);
    plan_text("0x1F", -1, 1, ST_OK, 64'd31);
    plan_text("0XffK", -1, 1, ST_OK, 64'd261120);
    plan_text("9223372036854775807", -1, 1, ST_OK, S64Max);
    plan_text("-9223372036854775808", -1, 1, ST_OK, S64Min);
    plan_text("99999999999999999999", -1, 1, ST_OK, S64Max);
    plan_text("-99999999999999999999", -1, 1, ST_OK, S64Min);
    plan_text("0x7fffFFFFffffFFFF", -1, 1, ST_OK, S64Max);
    plan_text("8T", -1, 1, ST_OK, 64'd8796093022208);
    plan_text("9999999t", -1, 1, ST_OK, S64Max);
    plan_text("3G 4", -1, 0, ST_OK, '0);
    plan_text("2g", -1, 0, ST_OK, '0);
    plan_text(" 4 M xyz", -1, 0, ST_OK, '0);
    // whitespace only, and a NUL in front of everything
    plan_text("   ", -1, 1, ST_EMPTY, '0);
    plan_text("?12", 0, 1, ST_EMPTY, '0);
    // NUL cuts the string, the rest up to last is dropped
    plan_text("12?34", 2, 1, ST_OK, 64'd12);
    plan_text("-", -1, 1, ST_NO_DIGITS, '0);
    plan_text("abc", -1, 1, ST_NO_DIGITS, '0);
    plan_text("\377", -1, 1, ST_NO_DIGITS, '0);
    // a sign in front of 0x keeps decimal, so x lands as a bad suffix
    plan_text("+0x10", -1, 1, ST_BAD_SUFFIX, '0);
    plan_text("0x", -1, 1, ST_BAD_SUFFIX, '0);
    plan_text("0xg", -1, 1, ST_BAD_SUFFIX, '0);
    plan_text("12q", -1, 1, ST_BAD_SUFFIX, '0);
    plan_limits(-64'sd100, 64'sd1000);
    plan_text("1000", -1, 1, ST_OK, 64'd1000);
    plan_text("1001", -1, 1, ST_RANGE, '0);
    plan_text("-100", -1, 1, ST_OK, -64'sd100);
    plan_text("1K", -1, 1, ST_RANGE, '0);
    plan_text("1k", -1, 0, ST_OK, '0);
    plan_limits(64'sd0, 64'sd0);
    plan_text("0", -1, 1, ST_OK, 64'd0);
    plan_text("-1", -1, 1, ST_RANGE, '0);
    // crossed limits reject everything
    plan_limits(S64Max, S64Min);
    plan_text("0", -1, 1, ST_RANGE, '0);
    plan_limits(S64Min, S64Max);
    plan_text("-0x1", -1, 0, ST_OK, '0);
    plan_text("7", -1, 1, ST_OK, 64'd7);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        set_limits(plan[i].lo, plan[i].hi);
      end else begin
        text_buf.delete();
        for (int k = 0; k < plan[i].text.len(); k++) text_buf.push_back(plan[i].text[k]);
        if (plan[i].nul_at >= 0) text_buf[plan[i].nul_at] = ChNul;
        send_text(plan[i].typed, plan[i].st, plan[i].val);
      end
    end

    // random strings, with new limits every few dozen strings
    sent    = 0;
    strings = 0;
    while (sent < RandomBytes) begin
      if (strings % 40 == 39) begin
        wait_idle();
        lo = pick_limit();
        hi = pick_limit();
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        set_limits(lo, hi);
      end
      make_random_text();
      sent += text_buf.size();
      send_text(1'b0, ST_OK, '0);
      strings++;
    end

    wait_idle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
